[hw/rtl/hgcp_pkg.sv]
package hgcp_pkg;

	// Default sizing of the level stack and of the cell size cap.
	localparam int MAX_LEVELS_DEF = 6;
	localparam int MAX_SHIFT_DEF  = 16;

	// Field widths of the input word and the result word.
	localparam int POS_W   = 24;
	localparam int HALF_W  = 22;
	localparam int WORLD_W = 20;
	localparam int SHIFT_W = 4;
	localparam int NLVL_W  = 3;
	localparam int CELL_W  = 15;
	localparam int INDEX_W = 30;

	// Configuration port geometry.
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// Limits that the configured values are clamped to.
	localparam logic [WORLD_W-1:0] WORLD_MIN = 20'd512;
	localparam logic [SHIFT_W-1:0] SHIFT_LO  = 4'd5;
	localparam logic [SHIFT_W-1:0] SHIFT_HI  = 4'd12;

	// Register map, one register every four bytes.
	typedef enum logic [2:0] {
		REG_WORLD_WIDTH  = 3'd0,
		REG_WORLD_HEIGHT = 3'd1,
		REG_MIN_SHIFT_X  = 3'd2,
		REG_MIN_SHIFT_Y  = 3'd3,
		REG_NUM_LEVELS   = 3'd4,
		REG_ORIGIN_X     = 3'd5,
		REG_ORIGIN_Y     = 3'd6
	} cfg_reg_t;

endpackage

[hw/rtl/hierarchical_grid_cell_placement_unit.sv]
// Places one box (centre and half-extents on two axes) into the finest of up to MAX_LEVELS
// uniform grids whose single cell holds the whole box, and returns the level, the cell column
// and row and the linear cell index, or in_grid low when the box belongs to the top cell. The
// block takes one word per clock when the pipeline is not stalled. Stage
// one forms the corners relative to the origin, stage two tests every level in parallel, stage
// three picks the finest fitting level and stage four forms row * columns + column into the
// output register. Back-pressure on the result side stalls only the stages that are full, so
// bubbles close up. Configuration registers are to be written only while no word is in flight.
module hierarchical_grid_cell_placement_unit
	import hgcp_pkg::*;
#(
	parameter int MAX_LEVELS = MAX_LEVELS_DEF,
	parameter int MAX_SHIFT  = MAX_SHIFT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,

	// Configuration port.
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [DATA_W-1:0]         pwdata,
	output logic [DATA_W-1:0]         prdata,
	output logic                      pready,

	// Box word.
	input  logic                      item_valid,
	output logic                      item_ready,
	input  logic signed [POS_W-1:0]   center_x,
	input  logic signed [POS_W-1:0]   center_y,
	input  logic [HALF_W-1:0]         half_extent_x,
	input  logic [HALF_W-1:0]         half_extent_y,

	// Placement word.
	output logic                      result_valid,
	input  logic                      result_ready,
	output logic                      in_grid,
	output logic [NLVL_W-1:0]         level,
	output logic [CELL_W-1:0]         cell_col,
	output logic [CELL_W-1:0]         cell_row,
	output logic [INDEX_W-1:0]        cell_index
);

	localparam int REL_W  = POS_W + 1;
	localparam int CORN_W = POS_W + 2;
	localparam int CNT_W  = CELL_W + 1;
	localparam int SH_W   = 5;

	// Configuration registers.
	logic [WORLD_W-1:0]      world_width_q, world_height_q;
	logic [SHIFT_W-1:0]      min_shift_x_q, min_shift_y_q;
	logic [NLVL_W-1:0]       num_levels_q;
	logic signed [POS_W-1:0] origin_x_q, origin_y_q;

	// Values in use after clamping.
	logic [WORLD_W-1:0] ww, wh;
	logic [SHIFT_W-1:0] bx, by;
	logic [NLVL_W-1:0]  nl;

	// Stage enables.
	logic en1, en2, en3, en4;

	// Stage one: corners relative to the origin.
	logic             v1_s1;
	logic             lo_ok_x_s1, lo_ok_y_s1;
	logic [REL_W-1:0] lo_x_s1, hi_x_s1, lo_y_s1, hi_y_s1;

	// Stage two: per-level fit and cell.
	logic              v2_s2;
	logic              hit_s2  [MAX_LEVELS];
	logic [CELL_W-1:0] col_s2  [MAX_LEVELS];
	logic [CELL_W-1:0] row_s2  [MAX_LEVELS];
	logic [CNT_W-1:0]  ncol_s2 [MAX_LEVELS];

	// Stage three: the chosen level.
	logic              v3_s3, hit_s3;
	logic [NLVL_W-1:0] level_s3;
	logic [CELL_W-1:0] col_s3, row_s3;
	logic [CNT_W-1:0]  ncol_s3;

	// Stage four: the output register.
	logic               v4_s4, in_grid_s4;
	logic [NLVL_W-1:0]  level_s4;
	logic [CELL_W-1:0]  col_s4, row_s4;
	logic [INDEX_W-1:0] index_s4;

	// Combinational terms of each stage.
	logic signed [REL_W-1:0]  rel_x, rel_y;
	logic signed [CORN_W-1:0] lo_x, hi_x, lo_y, hi_y;
	logic                     hit_c  [MAX_LEVELS];
	logic [CELL_W-1:0]        col_c  [MAX_LEVELS];
	logic [CELL_W-1:0]        row_c  [MAX_LEVELS];
	logic [CNT_W-1:0]         ncol_c [MAX_LEVELS];
	logic                     pick_hit;
	logic [NLVL_W-1:0]        pick_lvl;
	logic [CELL_W-1:0]        pick_col, pick_row;
	logic [CNT_W-1:0]         pick_ncol;
	logic [CELL_W+CNT_W-1:0]  prod;
	logic [INDEX_W-1:0]       index_c;

	assign pready = 1'b1;

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			world_width_q  <= WORLD_MIN;
			world_height_q <= WORLD_MIN;
			min_shift_x_q  <= SHIFT_LO;
			min_shift_y_q  <= SHIFT_LO;
			num_levels_q   <= NLVL_W'(1);
			origin_x_q     <= '0;
			origin_y_q     <= '0;
		end else if (psel && penable && pwrite) begin
			case (cfg_reg_t'(paddr[4:2]))
				REG_WORLD_WIDTH:  world_width_q  <= pwdata[WORLD_W-1:0];
				REG_WORLD_HEIGHT: world_height_q <= pwdata[WORLD_W-1:0];
				REG_MIN_SHIFT_X:  min_shift_x_q  <= pwdata[SHIFT_W-1:0];
				REG_MIN_SHIFT_Y:  min_shift_y_q  <= pwdata[SHIFT_W-1:0];
				REG_NUM_LEVELS:   num_levels_q   <= pwdata[NLVL_W-1:0];
				REG_ORIGIN_X:     origin_x_q     <= pwdata[POS_W-1:0];
				REG_ORIGIN_Y:     origin_y_q     <= pwdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		prdata = '0;
		case (cfg_reg_t'(paddr[4:2]))
			REG_WORLD_WIDTH:  prdata = DATA_W'(world_width_q);
			REG_WORLD_HEIGHT: prdata = DATA_W'(world_height_q);
			REG_MIN_SHIFT_X:  prdata = DATA_W'(min_shift_x_q);
			REG_MIN_SHIFT_Y:  prdata = DATA_W'(min_shift_y_q);
			REG_NUM_LEVELS:   prdata = DATA_W'(num_levels_q);
			REG_ORIGIN_X:     prdata = DATA_W'(unsigned'(origin_x_q));
			REG_ORIGIN_Y:     prdata = DATA_W'(unsigned'(origin_y_q));
			default:          prdata = '0;
		endcase
	end

	// Clamp the configured values to their usable ranges.
	always_comb begin
		ww = (world_width_q  < WORLD_MIN) ? WORLD_MIN : world_width_q;
		wh = (world_height_q < WORLD_MIN) ? WORLD_MIN : world_height_q;
		bx = (min_shift_x_q < SHIFT_LO) ? SHIFT_LO :
		     (min_shift_x_q > SHIFT_HI) ? SHIFT_HI : min_shift_x_q;
		by = (min_shift_y_q < SHIFT_LO) ? SHIFT_LO :
		     (min_shift_y_q > SHIFT_HI) ? SHIFT_HI : min_shift_y_q;
		nl = (num_levels_q == '0) ? NLVL_W'(1) :
		     (num_levels_q > NLVL_W'(MAX_LEVELS)) ? NLVL_W'(MAX_LEVELS) : num_levels_q;
	end

	// A stage moves on when it is empty or the stage after it moves on.
	assign en4        = !v4_s4 || result_ready;
	assign en3        = !v3_s3 || en4;
	assign en2        = !v2_s2 || en3;
	assign en1        = !v1_s1 || en2;
	assign item_ready = en1;

	// Stage one: both corners of the box on each axis.
	always_comb begin
		rel_x = REL_W'(center_x) - REL_W'(origin_x_q);
		rel_y = REL_W'(center_y) - REL_W'(origin_y_q);
		lo_x  = CORN_W'(rel_x) - signed'(CORN_W'(half_extent_x));
		hi_x  = CORN_W'(rel_x) + signed'(CORN_W'(half_extent_x));
		lo_y  = CORN_W'(rel_y) - signed'(CORN_W'(half_extent_y));
		hi_y  = CORN_W'(rel_y) + signed'(CORN_W'(half_extent_y));
	end

	// Stage two: test each level; a negative low corner rejects every level.
	always_comb begin
		logic [SH_W-1:0]  cnt_x, cnt_y, sz_x, sz_y;
		logic [REL_W-1:0] cx, cy;
		logic [CNT_W-1:0] nx, ny;
		logic             fx, fy;
		for (int i = 0; i < MAX_LEVELS; i++) begin
			cnt_x = SH_W'(bx) + SH_W'(i);
			cnt_y = SH_W'(by) + SH_W'(i);
			sz_x  = (cnt_x > SH_W'(MAX_SHIFT)) ? SH_W'(MAX_SHIFT) : cnt_x;
			sz_y  = (cnt_y > SH_W'(MAX_SHIFT)) ? SH_W'(MAX_SHIFT) : cnt_y;
			nx    = CNT_W'(CELL_W'(ww >> cnt_x)) + CNT_W'(1);
			ny    = CNT_W'(CELL_W'(wh >> cnt_y)) + CNT_W'(1);
			cx    = lo_x_s1 >> sz_x;
			cy    = lo_y_s1 >> sz_y;
			fx    = lo_ok_x_s1 && (cx < REL_W'(nx)) && ((hi_x_s1 >> sz_x) == cx);
			fy    = lo_ok_y_s1 && (cy < REL_W'(ny)) && ((hi_y_s1 >> sz_y) == cy);
			hit_c[i]  = fx && fy && (NLVL_W'(i) < nl);
			col_c[i]  = cx[CELL_W-1:0];
			row_c[i]  = cy[CELL_W-1:0];
			ncol_c[i] = nx;
		end
	end

	// Stage three: the finest fitting level wins.
	always_comb begin
		pick_hit  = 1'b0;
		pick_lvl  = '0;
		pick_col  = '0;
		pick_row  = '0;
		pick_ncol = '0;
		for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
			if (hit_s2[i]) begin
				pick_hit  = 1'b1;
				pick_lvl  = NLVL_W'(i);
				pick_col  = col_s2[i];
				pick_row  = row_s2[i];
				pick_ncol = ncol_s2[i];
			end
		end
	end

	// Stage four: linear cell index.
	assign prod    = row_s3 * ncol_s3;
	assign index_c = prod[INDEX_W-1:0] + INDEX_W'(col_s3);

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= item_valid;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
		end
	end

	// Payload of the pipeline.
	always_ff @(posedge clk) begin
		if (en1) begin
			lo_ok_x_s1 <= !lo_x[CORN_W-1];
			lo_ok_y_s1 <= !lo_y[CORN_W-1];
			lo_x_s1    <= lo_x[REL_W-1:0];
			hi_x_s1    <= hi_x[REL_W-1:0];
			lo_y_s1    <= lo_y[REL_W-1:0];
			hi_y_s1    <= hi_y[REL_W-1:0];
		end
		if (en2) begin
			hit_s2  <= hit_c;
			col_s2  <= col_c;
			row_s2  <= row_c;
			ncol_s2 <= ncol_c;
		end
		if (en3) begin
			hit_s3   <= pick_hit;
			level_s3 <= pick_lvl;
			col_s3   <= pick_col;
			row_s3   <= pick_row;
			ncol_s3  <= pick_ncol;
		end
		if (en4) begin
			in_grid_s4 <= hit_s3;
			level_s4   <= hit_s3 ? level_s3 : '0;
			col_s4     <= hit_s3 ? col_s3   : '0;
			row_s4     <= hit_s3 ? row_s3   : '0;
			index_s4   <= hit_s3 ? index_c  : '0;
		end
	end

	assign result_valid = v4_s4;
	assign in_grid      = in_grid_s4;
	assign level        = level_s4;
	assign cell_col     = col_s4;
	assign cell_row     = row_s4;
	assign cell_index   = index_s4;

	// A top-cell word carries all-zero placement fields.
	a_top_cell_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !in_grid) |->
			(level == '0 && cell_col == '0 && cell_row == '0 && cell_index == '0))
		else $error("top-cell word with non-zero placement");

	// The chosen level always lies within the levels in use.
	a_level_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(v3_s3 && hit_s3) |-> (level_s3 < nl))
		else $error("chosen level beyond the levels in use");

	// A stalled third stage keeps its word.
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v3_s3 && !en3) |=> (v3_s3 && $stable(level_s3) && $stable(hit_s3)))
		else $error("third stage lost its word under a stall");

	// A full pipeline stops taking words while the result is not taken.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_s1 && v2_s2 && v3_s3 && v4_s4 && !result_ready) |-> !item_ready)
		else $error("word taken into a full, stalled pipeline");

endmodule
